@@ design/phase_current_offset_calibration_defines.svh @@
// Assertion macros shared by the phase current offset calibration RTL.
`ifndef PHASE_CURRENT_OFFSET_CALIBRATION_DEFINES_SVH
`define PHASE_CURRENT_OFFSET_CALIBRATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCOC_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/pcoc_pkg.sv @@
// Shared widths, types and helpers for the phase current offset calibration block.
`timescale 1ns / 1ps
`default_nettype none

package pcoc_pkg;

	localparam int RAW_W      = 12;
	localparam int OFS_FRAC   = 8;
	localparam int SUM_W      = 20;
	localparam int DVD_W      = SUM_W + OFS_FRAC;
	localparam int AMPS_W     = 16;
	localparam int CUR_W      = 24;
	localparam int WIDE_W     = CUR_W + 2;
	localparam int FRAC_SHIFT = 12;

	localparam logic [AMPS_W-1:0] AMPS_RESET = 16'd1024;

	localparam logic signed [WIDE_W-1:0] WIDE_MAX = 26'sd8388607;
	localparam logic signed [WIDE_W-1:0] WIDE_MIN = -26'sd8388608;

	typedef logic signed [CUR_W-1:0] cur_t;

	// Status of the calibration unit as seen by the datapath.
	typedef struct packed {
		logic finished;
		logic forming;
	} pcoc_stat_t;

	function automatic cur_t sat_cur(input logic signed [WIDE_W-1:0] v);
		if (v > WIDE_MAX) begin
			return {1'b0, {(CUR_W-1){1'b1}}};
		end else if (v < WIDE_MIN) begin
			return {1'b1, {(CUR_W-1){1'b0}}};
		end else begin
			return v[CUR_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

@@ design/pcoc_scale.sv @@
// Offset removal, gain scaling, rounding and saturation for one phase sample.
`timescale 1ns / 1ps
`default_nettype none

module pcoc_scale (
	input  wire logic [pcoc_pkg::RAW_W-1:0]  raw,
	input  wire logic [pcoc_pkg::SUM_W-1:0]  offset,
	input  wire logic [pcoc_pkg::AMPS_W-1:0] amps_per_count,
	output pcoc_pkg::cur_t                   current
);
	import pcoc_pkg::*;

	localparam int DIFF_W = SUM_W + 1;
	localparam int PROD_W = DIFF_W + AMPS_W + 1;
	localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1 << (FRAC_SHIFT - 1));

	logic signed [DIFF_W-1:0] diff;
	logic signed [AMPS_W:0]   gain;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] rounded;
	logic signed [WIDE_W-1:0] scaled;

	// Sample is moved onto the offset's fixed point grid before the subtraction.
	assign diff    = $signed({1'b0, raw, {OFS_FRAC{1'b0}}}) - $signed({1'b0, offset});
	assign gain    = $signed({1'b0, amps_per_count});
	assign prod    = diff * gain;
	assign rounded = prod + ROUND_BIAS;
	assign scaled  = rounded[PROD_W-1 -: WIDE_W];
	assign current = sat_cur(scaled);

endmodule

`default_nettype wire

@@ design/pcoc_calib.sv @@
// Calibration accumulator and reciprocal-multiply offset forming for both phases.
`timescale 1ns / 1ps
`default_nettype none
`include "phase_current_offset_calibration_defines.svh"

module pcoc_calib #(
	parameter int CAL_SAMPLES = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_fire,
	input  wire logic [pcoc_pkg::RAW_W-1:0] raw_a,
	input  wire logic                       valid_a,
	input  wire logic [pcoc_pkg::RAW_W-1:0] raw_b,
	input  wire logic                       valid_b,
	output pcoc_pkg::pcoc_stat_t            stat,
	output logic [pcoc_pkg::SUM_W-1:0]      offset_a,
	output logic [pcoc_pkg::SUM_W-1:0]      offset_b
);
	import pcoc_pkg::*;

	localparam int CNT_W    = $clog2(CAL_SAMPLES + 1);
	localparam int RECIP_SH = DVD_W + $clog2(CAL_SAMPLES);
	localparam int RECIP_W  = DVD_W + 2;
	localparam int QPROD_W  = SUM_W + RECIP_W;
	localparam int Q_LSB    = RECIP_SH - OFS_FRAC;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAL_SAMPLES);
	// The reciprocal is rounded up with enough extra bits that the quotient is
	// exact for every dividend below two to the power of the dividend width.
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SH) +
		64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

	logic [CNT_W-1:0]   cnt_q;
	logic               fin_q;
	logic [SUM_W-1:0]   sum_q [2];
	logic [SUM_W-1:0]   ofs_q [2];
	logic [RAW_W-1:0]   raw   [2];
	logic [QPROD_W-1:0] qprod [2];
	logic               forming;

	assign raw[0]  = raw_a;
	assign raw[1]  = raw_b;
	assign forming = !fin_q && (cnt_q == CNT_FULL);

	// The dividend is the sum with eight zero fraction bits, so the shift that
	// follows the multiplication is shortened by those eight bits.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			qprod[i] = QPROD_W'(sum_q[i]) * QPROD_W'(RECIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fin_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				sum_q[i] <= '0;
				ofs_q[i] <= '0;
			end
		end else if (in_fire && !fin_q) begin
			if (forming) begin
				cnt_q <= '0;
				fin_q <= 1'b1;
				for (int i = 0; i < 2; i++) begin
					ofs_q[i] <= qprod[i][Q_LSB +: SUM_W];
					sum_q[i] <= '0;
				end
			end else if (valid_a && valid_b) begin
				cnt_q <= cnt_q + CNT_W'(1);
				for (int i = 0; i < 2; i++) begin
					sum_q[i] <= sum_q[i] + SUM_W'(raw[i]);
				end
			end
		end
	end

	assign stat.finished = fin_q;
	assign stat.forming  = forming;
	assign offset_a      = ofs_q[0];
	assign offset_b      = ofs_q[1];

	`PCOC_ASSERT_NEXT(a_form_done, clk, arst_n, in_fire && forming, fin_q,
		"offset beat did not end calibration")
	`PCOC_ASSERT_HOLDS(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CNT_FULL,
		"pair count ran past its limit")
	`PCOC_ASSERT_HOLDS(a_cnt_clear, clk, arst_n, fin_q, cnt_q == '0,
		"pair count not cleared after calibration")

endmodule

`default_nettype wire

@@ design/phase_current_offset_calibration.sv @@
// Top level of the phase current offset calibration and scaling block.
// Each accepted input beat is registered in the s1 stage and then in the result register.
// Throughput: one beat per cycle; the input is held off only while a result waits
// for out_ready.
// Reset clears counters, sums, offsets and held currents and loads amps_per_count with 1024.
`timescale 1ns / 1ps
`default_nettype none
`include "phase_current_offset_calibration_defines.svh"

module phase_current_offset_calibration #(
	parameter int CAL_SAMPLES = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [pcoc_pkg::AMPS_W-1:0] cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [pcoc_pkg::RAW_W-1:0]  raw_a,
	input  wire logic                        valid_a,
	input  wire logic [pcoc_pkg::RAW_W-1:0]  raw_b,
	input  wire logic                        valid_b,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output pcoc_pkg::cur_t                   current_a,
	output pcoc_pkg::cur_t                   current_b,
	output pcoc_pkg::cur_t                   current_c,
	output logic                             measure_ok,
	output logic                             calibrated
);
	import pcoc_pkg::*;

	logic [AMPS_W-1:0]   amps_per_count_q;
	pcoc_stat_t          stat;
	logic [SUM_W-1:0]    offset_a;
	logic [SUM_W-1:0]    offset_b;
	cur_t                scaled_a;
	cur_t                scaled_b;
	logic                advance;
	logic                in_fire;

	logic                valid_s1;
	logic                run_s1;
	logic                va_s1;
	logic                vb_s1;
	logic                cal_s1;
	cur_t                cur_a_s1;
	cur_t                cur_b_s1;

	logic                out_valid_q;
	logic                measure_ok_q;
	logic                calibrated_q;
	cur_t                held_a_q;
	cur_t                held_b_q;
	cur_t                held_c_q;
	logic signed [WIDE_W-1:0] sum_ab;
	logic signed [WIDE_W-1:0] wide_a;
	logic signed [WIDE_W-1:0] wide_b;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amps_per_count_q <= AMPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			amps_per_count_q <= cfg_data;
		end
	end

	// The whole pipeline moves together whenever the result register is free.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;
	assign in_fire  = in_valid && in_ready;

	pcoc_calib #(
		.CAL_SAMPLES(CAL_SAMPLES)
	) u_calib (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.raw_a    (raw_a),
		.valid_a  (valid_a),
		.raw_b    (raw_b),
		.valid_b  (valid_b),
		.stat     (stat),
		.offset_a (offset_a),
		.offset_b (offset_b)
	);

	pcoc_scale u_scale_a (
		.raw            (raw_a),
		.offset         (offset_a),
		.amps_per_count (amps_per_count_q),
		.current        (scaled_a)
	);

	pcoc_scale u_scale_b (
		.raw            (raw_b),
		.offset         (offset_b),
		.amps_per_count (amps_per_count_q),
		.current        (scaled_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_fire) begin
			run_s1   <= stat.finished;
			va_s1    <= valid_a;
			vb_s1    <= valid_b;
			cal_s1   <= stat.finished || stat.forming;
			cur_a_s1 <= scaled_a;
			cur_b_s1 <= scaled_b;
		end
	end

	// Phase C is only refreshed when both phases were freshly measured, so it
	// is formed from the new values of this beat.
	assign wide_a = WIDE_W'(cur_a_s1);
	assign wide_b = WIDE_W'(cur_b_s1);
	assign sum_ab = wide_a + wide_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			measure_ok_q <= 1'b0;
			calibrated_q <= 1'b0;
			held_a_q     <= '0;
			held_b_q     <= '0;
			held_c_q     <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				measure_ok_q <= run_s1 && va_s1 && vb_s1;
				calibrated_q <= cal_s1;
				if (run_s1 && va_s1) begin
					held_a_q <= cur_a_s1;
				end
				if (run_s1 && vb_s1) begin
					held_b_q <= cur_b_s1;
				end
				if (run_s1 && va_s1 && vb_s1) begin
					held_c_q <= sat_cur(-sum_ab);
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign current_a  = held_a_q;
	assign current_b  = held_b_q;
	assign current_c  = held_c_q;
	assign measure_ok = measure_ok_q;
	assign calibrated = calibrated_q;

	`PCOC_ASSERT_HOLDS(a_ok_needs_cal, clk, arst_n, out_valid_q && measure_ok_q, calibrated_q,
		"measurement reported before calibration")
	`PCOC_ASSERT_NEXT(a_cal_sticky, clk, arst_n, calibrated_q, calibrated_q,
		"calibrated flag fell")
	`PCOC_ASSERT_HOLDS(a_stall_in, clk, arst_n, out_valid_q && !out_ready, !in_ready,
		"input taken while a result waited")

endmodule

`default_nettype wire

@@ sim/phase_current_offset_calibration_tb.sv @@
// Testbench for the phase current offset calibration block: calibration, scaling and backpressure.
`timescale 1ns / 1ps

module phase_current_offset_calibration_tb;
	import pcoc_pkg::*;

	localparam int CAL_SAMPLES = 64;
	localparam int REPORT_LIMIT = 10;
	localparam int HOLD_OFF_CYCLES = 150;
	// Covers the result latency with ample margin for random result stalls.
	localparam int SETTLE_CYCLES = 32;

	typedef struct packed {
		cur_t a;
		cur_t b;
		cur_t c;
		logic ok;
		logic cal;
	} phase_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [AMPS_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic [RAW_W-1:0] raw_a = '0;
	logic valid_a = 1'b0;
	logic [RAW_W-1:0] raw_b = '0;
	logic valid_b = 1'b0;
	logic out_ready = 1'b0;
	logic cfg_ready;
	logic in_ready;
	logic out_valid;
	cur_t current_a;
	cur_t current_b;
	cur_t current_c;
	logic measure_ok;
	logic calibrated;

	// Shared stimulus controls, written with nonblocking assignments.
	bit steady = 1'b0;
	int hold_off_req = 0;

	// Predictor state.
	logic [AMPS_W-1:0] scale_now = AMPS_RESET;
	int cal_pairs = 0;
	logic [19:0] acc_a = '0;
	logic [19:0] acc_b = '0;
	logic [19:0] ofs_a = '0;
	logic [19:0] ofs_b = '0;
	bit cal_finished = 1'b0;
	cur_t held_a = '0;
	cur_t held_b = '0;
	cur_t held_c = '0;
	phase_result_t expected_currents[$];
	int errors = 0;

	phase_current_offset_calibration #(
		.CAL_SAMPLES(CAL_SAMPLES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_a(raw_a),
		.valid_a(valid_a),
		.raw_b(raw_b),
		.valid_b(valid_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.current_a(current_a),
		.current_b(current_b),
		.current_c(current_c),
		.measure_ok(measure_ok),
		.calibrated(calibrated)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic cur_t clamp24(input longint v);
		if (v > 64'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -64'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	// The product carries 12 fractional bits; adding half an LSB and flooring rounds half up.
	function automatic cur_t scaled_current(input logic [RAW_W-1:0] raw, input logic [19:0] ofs);
		longint diff;
		longint prod;
		diff = longint'({raw, 8'h00}) - longint'(ofs);
		prod = diff * longint'(scale_now) + 64'sd2048;
		return clamp24(prod >>> 12);
	endfunction

	function automatic phase_result_t predict_currents(input logic [RAW_W-1:0] ra, input logic va,
			input logic [RAW_W-1:0] rb, input logic vb);
		phase_result_t r;
		logic [27:0] q;
		r.ok = 1'b0;
		if (!cal_finished) begin
			if (cal_pairs < CAL_SAMPLES) begin
				if (va && vb) begin
					acc_a = acc_a + 20'(ra);
					acc_b = acc_b + 20'(rb);
					cal_pairs++;
				end
			end else begin
				// This beat only forms the offsets; its samples are dropped.
				q = 28'({acc_a, 8'h00} / CAL_SAMPLES);
				ofs_a = q[19:0];
				q = 28'({acc_b, 8'h00} / CAL_SAMPLES);
				ofs_b = q[19:0];
				acc_a = '0;
				acc_b = '0;
				cal_pairs = 0;
				cal_finished = 1'b1;
			end
		end else begin
			if (va) begin
				held_a = scaled_current(ra, ofs_a);
			end
			if (vb) begin
				held_b = scaled_current(rb, ofs_b);
			end
			if (va && vb) begin
				held_c = clamp24(-(longint'(held_a) + longint'(held_b)));
				r.ok = 1'b1;
			end
		end
		r.a = held_a;
		r.b = held_b;
		r.c = held_c;
		r.cal = cal_finished;
		return r;
	endfunction

	always @(posedge clk) begin : check_results
		phase_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready === 1'b1) begin
				scale_now = cfg_data;
			end
			if (in_valid && in_ready === 1'b1) begin
				expected_currents.push_back(predict_currents(raw_a, valid_a, raw_b, valid_b));
			end
			if (out_valid === 1'b1 && out_ready) begin
				if (expected_currents.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT) begin
						$display("%0t: unexpected result a=%0d b=%0d c=%0d ok=%b cal=%b", $realtime,
							current_a, current_b, current_c, measure_ok, calibrated);
					end
				end else begin
					want = expected_currents.pop_front();
					if (current_a !== want.a || current_b !== want.b || current_c !== want.c ||
							measure_ok !== want.ok || calibrated !== want.cal) begin
						errors++;
						if (errors <= REPORT_LIMIT) begin
							$display("%0t: expected a=%0d b=%0d c=%0d ok=%b cal=%b", $realtime,
								want.a, want.b, want.c, want.ok, want.cal);
							$display("%0t:   actual a=%0d b=%0d c=%0d ok=%b cal=%b", $realtime,
								current_a, current_b, current_c, measure_ok, calibrated);
						end
					end
				end
			end
		end
	end

	// Result side: random stalls, or a long counted hold-off when one is requested.
	always @(posedge clk) begin : drive_out_ready
		int hold_seen;
		int hold_left;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_seen = 0;
			hold_left = 0;
		end else if (hold_seen != hold_off_req) begin
			hold_seen = hold_off_req;
			hold_left = HOLD_OFF_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 37);
		end
	end

	task automatic send_pair(input logic [RAW_W-1:0] ra, input logic va,
			input logic [RAW_W-1:0] rb, input logic vb);
		if (!steady && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 37);
		end
		in_valid <= 1'b1;
		raw_a <= ra;
		valid_a <= va;
		raw_b <= rb;
		valid_b <= vb;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	function automatic logic [RAW_W-1:0] pick_raw();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return RAW_W'($urandom_range(4095));
		endcase
	endfunction

	task automatic send_random_pair();
		int k;
		k = $urandom_range(99);
		send_pair(pick_raw(), k < 75, pick_raw(), (k < 60) || (k >= 75 && k < 90));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_currents.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_scale(input logic [AMPS_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	// Phase A settles near 1000 counts and phase B near 3000, so that both
	// saturation directions are reachable later. The sum of A is made odd so
	// that exact half-LSB products turn up once the scale is a power of two.
	task automatic test_calibration();
		int sum_a_seen;
		int sum_b_seen;
		int k;
		logic [RAW_W-1:0] ra;
		logic [RAW_W-1:0] rb;
		sum_a_seen = 0;
		sum_b_seen = 0;
		send_pair('1, 1'b1, '0, 1'b0);
		send_pair('0, 1'b0, '1, 1'b1);
		send_pair('1, 1'b0, '1, 1'b0);
		for (int i = 0; i < CAL_SAMPLES; i++) begin
			if ($urandom_range(99) < 15) begin
				k = $urandom_range(2);
				send_pair(pick_raw(), k == 0, pick_raw(), k == 1);
			end
			if (i == 0) begin
				ra = '0;
				rb = '1;
			end else begin
				ra = RAW_W'($urandom_range(1100, 900));
				rb = RAW_W'($urandom_range(3100, 2900));
			end
			if (i == CAL_SAMPLES - 1) begin
				ra[0] = ~sum_a_seen[0];
				rb[0] = sum_b_seen[0];
			end
			sum_a_seen += ra;
			sum_b_seen += rb;
			send_pair(ra, 1'b1, rb, 1'b1);
		end
		send_pair(pick_raw(), 1'b1, pick_raw(), 1'b1);
	endtask

	task automatic test_default_scale();
		send_pair(12'd1000, 1'b1, 12'd3000, 1'b1);
		send_pair('1, 1'b1, '0, 1'b1);
		send_pair('0, 1'b1, '1, 1'b0);
	endtask

	task automatic test_scaling_extremes();
		logic [AMPS_W-1:0] scales[2];
		scales[0] = '1;
		scales[1] = '0;
		foreach (scales[s]) begin
			set_scale(scales[s]);
			send_pair('1, 1'b1, '0, 1'b1);
			send_pair('0, 1'b1, '1, 1'b1);
			send_pair('1, 1'b1, '1, 1'b1);
			send_pair('0, 1'b1, '0, 1'b1);
			send_pair('1, 1'b1, '1, 1'b0);
			send_pair('1, 1'b0, '0, 1'b1);
			send_pair('0, 1'b0, '1, 1'b0);
		end
	endtask

	task automatic test_full_rate();
		set_scale(AMPS_RESET);
		steady <= 1'b1;
		repeat (200) send_random_pair();
		steady <= 1'b0;
	endtask

	// The sender keeps offering beats while the result side is held off,
	// so the block fills up and must stall its input.
	task automatic test_backpressure();
		set_scale(16'd3000);
		hold_off_req <= hold_off_req + 1;
		steady <= 1'b1;
		repeat (120) send_random_pair();
		steady <= 1'b0;
	endtask

	task automatic test_random_scales();
		logic [AMPS_W-1:0] value;
		for (int p = 0; p < 9; p++) begin
			case (p)
				0: value = 16'h0001;
				1: value = 16'h0200;
				2: value = '1;
				3: value = '0;
				default: value = AMPS_W'($urandom_range(65535));
			endcase
			set_scale(value);
			repeat (170) send_random_pair();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_calibration();
		test_default_scale();
		test_scaling_extremes();
		test_full_rate();
		test_backpressure();
		test_random_scales();
		in_valid <= 1'b0;
		for (int i = 0; i < 2000 && expected_currents.size() != 0; i++) @(posedge clk);
		repeat (8) @(posedge clk);
		errors += expected_currents.size();
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
